[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks on the collision search ports.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ncts_pkg.sv]
// ---------------------------------------------------------------------------
// ncts_pkg
// Shared types and constants of the next collision time search.
// ---------------------------------------------------------------------------
package ncts_pkg;

  localparam int MaxParticles = 64;
  localparam int QueueDepth   = 2;
  localparam logic [30:0] GravityReset = 31'd642;

  // Kind of work handed from the front end to the back end.
  typedef enum logic [1:0] {
    KIND_FLOOR = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_SKIP  = 2'd2
  } kind_t;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SENT = 2'd2
  } status_t;

  // Back end sequence: radicand setup, root, divide and finish.
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_SQ, ST_MUL_GZ, ST_RAD, ST_SQRT, ST_LOAD, ST_DIV, ST_FIN
  } back_state_t;

  // For a floor item, mag is |v| and hgt is the height.
  // For a pair item, mag is |dv| and hgt is |dz|.
  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic        neg;
    logic [32:0] mag;
    logic [30:0] hgt;
  } entry_t;

endpackage

[hdl/next_collision_time_search.sv]
// ---------------------------------------------------------------------------
// next_collision_time_search
// Earliest next event (floor hit or pair collision) of a particle column.
// ---------------------------------------------------------------------------
//
//  channel   direction  words
//  s_axis    in         one particle: height, velocity, tlast = topmost
//  m_axis    out        one result per column: time, index, tuser = status
//  cfg       in         gravity register write
//
// A floor particle passes through two multiplies, a 32-step square root and a
// 49-step restoring divide in the back end. An approaching pair needs the
// divide only, and a receding pair skips both.
// The front end accepts words into a two-entry queue while the back end works,
// until the queue is full; a result waiting in the output register stalls the back end.
// Reset is synchronous and clears the column state and both handshakes.
module next_collision_time_search #(
  parameter int MAX_PARTICLES = ncts_pkg::MaxParticles
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // height[30:0], vertical_velocity[62:31], zero pad
  input  logic        s_axis_tlast,   // last_particle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // min_time[31:0], event_index[37:32], zero pad
  output logic [1:0]  m_axis_tuser,   // time_status
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data     // gravity
);

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int EW = $bits(ncts_pkg::entry_t) + IW;

  logic [30:0]       gravity;
  logic              q_push, q_full, q_valid, q_pop;
  ncts_pkg::entry_t  f_entry, b_entry;
  logic [IW-1:0]     f_idx, b_idx;
  logic [31:0]       res_time;
  logic [IW-1:0]     res_index;
  ncts_pkg::status_t res_status;

  // The gravity register is to be written only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= ncts_pkg::GravityReset;
    end else if (cfg_wr_en) begin
      gravity <= cfg_wr_data;
    end
  end

  ncts_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .height            (s_axis_tdata[30:0]),
    .vertical_velocity (s_axis_tdata[62:31]),
    .last_particle     (s_axis_tlast),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (f_entry),
    .q_idx             (f_idx)
  );

  ncts_fifo #(.WIDTH(EW), .DEPTH(ncts_pkg::QueueDepth)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_entry, f_idx}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  ({b_entry, b_idx})
  );

  ncts_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .gravity    (gravity),
    .q_valid    (q_valid),
    .q_entry    (b_entry),
    .q_idx      (b_idx),
    .q_pop      (q_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_time   (res_time),
    .res_index  (res_index),
    .res_status (res_status)
  );

  // The event index is reported in six bits whatever the column length.
  assign m_axis_tdata = {2'b00, 6'(res_index), res_time};
  assign m_axis_tuser = res_status;

endmodule

[hdl/ncts_fifo.sv]
// ---------------------------------------------------------------------------
// ncts_fifo
// Small register queue between the front end and the back end.
// ---------------------------------------------------------------------------
module ncts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + CW'(push && !full) - CW'(pop && not_empty);
    end
  end

endmodule

[hdl/ncts_front.sv]
// ---------------------------------------------------------------------------
// ncts_front
// Accepts particles, pairs each with its predecessor and classifies the work.
// ---------------------------------------------------------------------------
module ncts_front #(
  parameter int MAX_PARTICLES = ncts_pkg::MaxParticles
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [30:0]                      height,
  input  logic signed [31:0]               vertical_velocity,
  input  logic                             last_particle,
  input  logic                             q_full,
  output logic                             q_push,
  output ncts_pkg::entry_t                 q_entry,
  output logic [$clog2(MAX_PARTICLES)-1:0] q_idx
);

  localparam int IW = $clog2(MAX_PARTICLES);

  logic [IW-1:0]      count;
  logic [30:0]        prev_height;
  logic signed [31:0] prev_velocity;
  logic signed [32:0] dv;
  logic [32:0]        av;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_idx    = count;

  assign dv = 33'(vertical_velocity) - 33'(prev_velocity);
  assign av = vertical_velocity[31] ? -33'(vertical_velocity) : 33'(vertical_velocity);

  always_comb begin
    q_entry.last = last_particle;
    if (count == '0) begin
      q_entry.kind = ncts_pkg::KIND_FLOOR;
      q_entry.neg  = vertical_velocity[31];
      q_entry.mag  = av;
      q_entry.hgt  = height;
    end else begin
      q_entry.kind = dv[32] ? ncts_pkg::KIND_PAIR : ncts_pkg::KIND_SKIP;
      q_entry.neg  = 1'b0;
      q_entry.mag  = -dv;
      q_entry.hgt  = (height >= prev_height) ? height - prev_height : prev_height - height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      prev_height   <= '0;
      prev_velocity <= '0;
    end else if (q_push) begin
      prev_height   <= height;
      prev_velocity <= vertical_velocity;
      if (last_particle) begin
        count <= '0;
      end else if (count != IW'(MAX_PARTICLES - 1)) begin
        count <= count + IW'(1);
      end
    end
  end

endmodule

[hdl/ncts_back.sv]
// ---------------------------------------------------------------------------
// ncts_back
// Evaluates floor and pair times with an iterative root and a shared divider,
// keeps the running minimum and holds the result word.
// ---------------------------------------------------------------------------
module ncts_back #(
  parameter int MAX_PARTICLES = ncts_pkg::MaxParticles
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [30:0]                      gravity,
  input  logic                             q_valid,
  input  ncts_pkg::entry_t                 q_entry,
  input  logic [$clog2(MAX_PARTICLES)-1:0] q_idx,
  output logic                             q_pop,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [31:0]                      res_time,
  output logic [$clog2(MAX_PARTICLES)-1:0] res_index,
  output ncts_pkg::status_t                res_status
);

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int QW = 49;

  ncts_pkg::back_state_t state, state_next;

  ncts_pkg::entry_t cur;
  logic [IW-1:0]    cur_idx;
  logic [63:0]      prod_sq;
  logic [61:0]      prod_gz;
  logic [63:0]      rem;
  logic [63:0]      root;
  logic [63:0]      bitm;
  logic [QW-1:0]    dvd;
  logic [33:0]      drem;
  logic [32:0]      dsor;
  logic [5:0]       cnt;
  logic [31:0]      running_min;
  logic [IW-1:0]    min_index;
  logic             min_inf;

  logic             load_entry, emit_ok, fin_go;
  logic [63:0]      trial;
  logic             sq_ge;
  logic [33:0]      rs;
  logic             dv_ge;
  logic [31:0]      t_sat;
  logic [31:0]      rm_new;
  logic [IW-1:0]    idx_new;
  logic             inf_new;

  assign emit_ok = !res_valid || res_ready;
  assign trial   = root + bitm;
  assign sq_ge   = rem >= trial;
  assign rs      = {drem[32:0], dvd[QW-1]};
  assign dv_ge   = rs >= {1'b0, dsor};
  assign t_sat   = (|dvd[QW-1:32]) ? '1 : dvd[31:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ncts_pkg::ST_IDLE: begin
        if (q_valid) begin
          priority case (q_entry.kind)
            ncts_pkg::KIND_FLOOR: begin
              state_next = (gravity == '0) ? ncts_pkg::ST_FIN : ncts_pkg::ST_MUL_SQ;
            end
            ncts_pkg::KIND_PAIR: state_next = ncts_pkg::ST_LOAD;
            default:             state_next = ncts_pkg::ST_FIN;
          endcase
        end
      end
      ncts_pkg::ST_MUL_SQ: state_next = ncts_pkg::ST_MUL_GZ;
      ncts_pkg::ST_MUL_GZ: state_next = ncts_pkg::ST_RAD;
      ncts_pkg::ST_RAD:    state_next = ncts_pkg::ST_SQRT;
      ncts_pkg::ST_SQRT:   state_next = bitm[0] ? ncts_pkg::ST_LOAD : ncts_pkg::ST_SQRT;
      ncts_pkg::ST_LOAD:   state_next = ncts_pkg::ST_DIV;
      ncts_pkg::ST_DIV: begin
        state_next = (cnt == 6'(QW - 1)) ? ncts_pkg::ST_FIN : ncts_pkg::ST_DIV;
      end
      ncts_pkg::ST_FIN: begin
        state_next = (!cur.last || emit_ok) ? ncts_pkg::ST_IDLE : ncts_pkg::ST_FIN;
      end
      default: state_next = ncts_pkg::ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    load_entry = 1'b0;
    fin_go     = 1'b0;
    unique case (state)
      ncts_pkg::ST_IDLE: load_entry = q_valid;
      ncts_pkg::ST_FIN:  fin_go     = !cur.last || emit_ok;
      default: begin
        load_entry = 1'b0;
        fin_go     = 1'b0;
      end
    endcase
  end

  assign q_pop = load_entry;

  // Candidate minimum after this item.
  always_comb begin
    rm_new  = running_min;
    idx_new = min_index;
    inf_new = min_inf;
    if (cur.kind == ncts_pkg::KIND_FLOOR) begin
      rm_new  = (gravity == '0) ? '1 : t_sat;
      idx_new = '0;
      inf_new = (gravity == '0);
    end else if (cur.kind == ncts_pkg::KIND_PAIR) begin
      if (t_sat != '0 && t_sat < running_min) begin
        rm_new  = t_sat;
        idx_new = cur_idx;
        inf_new = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath. The root register holds the full shifted partial root, which
  // only settles to 32 bits at the last step.
  always_ff @(posedge clk) begin
    if (load_entry) begin
      cur     <= q_entry;
      cur_idx <= q_idx;
    end
    unique case (state)
      ncts_pkg::ST_MUL_SQ: prod_sq <= cur.mag[31:0] * cur.mag[31:0];
      ncts_pkg::ST_MUL_GZ: prod_gz <= gravity * cur.hgt;
      ncts_pkg::ST_RAD: begin
        rem  <= prod_sq + {prod_gz, 1'b0};
        root <= '0;
        bitm <= 64'd1 << 62;
      end
      ncts_pkg::ST_SQRT: begin
        if (sq_ge) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
      end
      ncts_pkg::ST_LOAD: begin
        drem <= '0;
        cnt  <= '0;
        if (cur.kind == ncts_pkg::KIND_FLOOR) begin
          dvd  <= QW'(cur.neg ? root - 64'(cur.mag) : root + 64'(cur.mag)) << 16;
          dsor <= 33'(gravity);
        end else begin
          dvd  <= QW'(cur.hgt) << 16;
          dsor <= cur.mag;
        end
      end
      ncts_pkg::ST_DIV: begin
        drem <= dv_ge ? rs - {1'b0, dsor} : rs;
        dvd  <= {dvd[QW-2:0], dv_ge};
        cnt  <= cnt + 6'd1;
      end
      default: begin
      end
    endcase
  end

  // Running minimum and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= '0;
      min_index   <= '0;
      min_inf     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (fin_go && cur.last) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (fin_go) begin
        if (cur.last) begin
          res_time    <= rm_new;
          res_index   <= idx_new;
          if (rm_new == '0) begin
            res_status <= ncts_pkg::STAT_ZERO;
          end else if (inf_new) begin
            res_status <= ncts_pkg::STAT_SENT;
          end else begin
            res_status <= ncts_pkg::STAT_OK;
          end
          running_min <= '0;
          min_index   <= '0;
          min_inf     <= 1'b0;
        end else begin
          running_min <= rm_new;
          min_index   <= idx_new;
          min_inf     <= inf_new;
        end
      end
    end
  end

endmodule

[hdl/ncts_checker.sv]
// ---------------------------------------------------------------------------
// ncts_checker
// Port-level checks of the collision time search result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ncts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic [31:0] m_time;
  logic [5:0]  m_index;
  logic        m_ok, m_zero, m_sent;

  assign m_time  = m_axis_tdata[31:0];
  assign m_index = m_axis_tdata[37:32];
  assign m_ok    = (m_axis_tuser == ncts_pkg::STAT_OK);
  assign m_zero  = (m_axis_tuser == ncts_pkg::STAT_ZERO);
  assign m_sent  = (m_axis_tuser == ncts_pkg::STAT_SENT);

  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `CHK_IMPLY(a_zero, clk, rst, m_axis_tvalid, m_zero == (m_time == 32'd0), "zero status mismatch")
  `CHK_IMPLY(a_sent, clk, rst, m_axis_tvalid && m_sent, m_time == '1 && m_index == '0, "bad sentinel")
  `CHK_IMPLY(a_code, clk, rst, m_axis_tvalid, (m_ok || m_zero || m_sent) && m_axis_tdata[39:38] == 2'd0, "bad code")

endmodule

bind next_collision_time_search ncts_checker u_ncts_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
